@@ design/ilp_pkg.sv @@
// shared types and constants for the integer literal parser
package ilp_pkg;

  // accumulator width, result width and count width
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned OUT_BITS   = 32;
  localparam int unsigned CNT_BITS   = 8;
  localparam int unsigned CHAR_BITS  = 8;
  // width used to sign-extend the accumulator before trimming to the result
  localparam int unsigned EXT_BITS   = 64;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  // parse phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_FIRST  = 5'b00010,
    PH_SIGNED = 5'b00100,
    PH_ZERO   = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_e;

  // number base
  typedef enum logic [1:0] {
    RAD_DEC = 2'd0,
    RAD_OCT = 2'd1,
    RAD_HEX = 2'd2
  } radix_e;

  // parser state carried from one character to the next
  typedef struct packed {
    phase_e                  phase;
    radix_e                  radix;
    logic                    neg;
    logic [VALUE_BITS-1:0]   acc;
    logic [CNT_BITS-1:0]     cnt;
  } ilp_state_t;

  // one result transaction
  typedef struct packed {
    logic                       success;
    logic signed [OUT_BITS-1:0] value;
    logic [CNT_BITS-1:0]        consumed;
  } ilp_result_t;

endpackage

@@ design/ilp_step.sv @@
// per-character next-state and result logic of the parser
module ilp_step (
  input  ilp_pkg::ilp_state_t               state_i,
  input  logic [ilp_pkg::CHAR_BITS-1:0]     char_i,
  input  logic                              start_i,
  output ilp_pkg::ilp_state_t               state_o,
  output logic                              emit_o,
  output ilp_pkg::ilp_result_t              result_o
);

  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_0      = 8'h30;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_8      = 8'h38;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_9      = 8'h39;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_MINUS  = 8'h2d;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_X_LO   = 8'h78;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_X_UP   = 8'h58;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_A_LO   = 8'h61;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_F_LO   = 8'h66;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_A_UP   = 8'h41;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] CH_F_UP   = 8'h46;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] HEX_LO_OFS = 8'h57;
  localparam logic [ilp_pkg::CHAR_BITS-1:0] HEX_UP_OFS = 8'h37;

  ilp_pkg::ilp_state_t st;
  logic       is_dec, is_lo, is_up;
  logic [3:0] dec_val, lo_val, up_val;
  logic       dig_ok;
  logic [3:0] dig_val;
  logic       dec_ok;
  logic [ilp_pkg::VALUE_BITS-1:0] acc_take;
  logic [ilp_pkg::VALUE_BITS-1:0] acc_dec;
  logic [ilp_pkg::CNT_BITS-1:0]   cnt_inc;
  logic signed [ilp_pkg::VALUE_BITS-1:0] signed_acc;
  logic [ilp_pkg::EXT_BITS-1:0]   wide;

  // character classes
  always_comb begin
    is_dec  = (char_i >= CH_0) && (char_i <= CH_9);
    is_lo   = (char_i >= CH_A_LO) && (char_i <= CH_F_LO);
    is_up   = (char_i >= CH_A_UP) && (char_i <= CH_F_UP);
    dec_val = 4'(char_i - CH_0);
    lo_val  = 4'(char_i - HEX_LO_OFS);
    up_val  = 4'(char_i - HEX_UP_OFS);
  end

  // state after an optional string start
  always_comb begin
    st = state_i;
    if (start_i) begin
      st.phase = ilp_pkg::PH_FIRST;
      st.radix = ilp_pkg::RAD_DEC;
      st.neg   = 1'b0;
      st.acc   = '0;
      st.cnt   = '0;
    end
  end

  // digit decode for the current base (the leading-zero phase is always octal)
  always_comb begin
    unique case (st.radix)
      ilp_pkg::RAD_OCT: begin
        dig_ok  = is_dec && (char_i != CH_8) && (char_i != CH_9);
        dig_val = dec_val;
      end
      ilp_pkg::RAD_HEX: begin
        dig_ok  = is_dec || is_lo || is_up;
        dig_val = is_dec ? dec_val : (is_lo ? lo_val : up_val);
      end
      default: begin
        dig_ok  = is_dec;
        dig_val = dec_val;
      end
    endcase
    dec_ok = is_dec;
  end

  // multiply-accumulate by 8, 10 or 16 with wrap
  always_comb begin
    unique case (st.radix)
      ilp_pkg::RAD_HEX: acc_take = (st.acc << 4) + ilp_pkg::VALUE_BITS'(dig_val);
      ilp_pkg::RAD_OCT: acc_take = (st.acc << 3) + ilp_pkg::VALUE_BITS'(dig_val);
      default:          acc_take = (st.acc << 3) + (st.acc << 1)
                                   + ilp_pkg::VALUE_BITS'(dig_val);
    endcase
    acc_dec = (st.acc << 3) + (st.acc << 1) + ilp_pkg::VALUE_BITS'(dec_val);
    cnt_inc = (st.cnt == ilp_pkg::CNT_MAX) ? st.cnt : st.cnt + 1'b1;
  end

  // result fields, computed from the state before the terminator
  always_comb begin
    signed_acc = st.neg ? signed'(ilp_pkg::VALUE_BITS'(0) - st.acc) : signed'(st.acc);
    wide       = ilp_pkg::EXT_BITS'(signed_acc);
    result_o.success  = (st.cnt != '0);
    result_o.value    = result_o.success ? signed'(wide[ilp_pkg::OUT_BITS-1:0]) : '0;
    result_o.consumed = st.cnt;
  end

  // phase transitions
  always_comb begin
    state_o = st;
    emit_o  = 1'b0;
    unique case (st.phase)
      ilp_pkg::PH_FIRST, ilp_pkg::PH_SIGNED: begin
        if ((st.phase == ilp_pkg::PH_FIRST) && (char_i == CH_MINUS)) begin
          state_o.neg   = 1'b1;
          state_o.cnt   = cnt_inc;
          state_o.phase = ilp_pkg::PH_SIGNED;
        end else if (char_i == CH_0) begin
          state_o.cnt   = cnt_inc;
          state_o.radix = ilp_pkg::RAD_OCT;
          state_o.phase = ilp_pkg::PH_ZERO;
        end else if (dec_ok) begin
          state_o.radix = ilp_pkg::RAD_DEC;
          state_o.acc   = acc_dec;
          state_o.cnt   = cnt_inc;
          state_o.phase = ilp_pkg::PH_DIGITS;
        end else begin
          emit_o        = 1'b1;
          state_o.phase = ilp_pkg::PH_IDLE;
        end
      end
      ilp_pkg::PH_ZERO: begin
        if ((char_i == CH_X_LO) || (char_i == CH_X_UP)) begin
          state_o.cnt   = cnt_inc;
          state_o.radix = ilp_pkg::RAD_HEX;
          state_o.phase = ilp_pkg::PH_DIGITS;
        end else if (dig_ok) begin
          state_o.acc   = acc_take;
          state_o.cnt   = cnt_inc;
          state_o.phase = ilp_pkg::PH_DIGITS;
        end else begin
          emit_o        = 1'b1;
          state_o.phase = ilp_pkg::PH_IDLE;
        end
      end
      ilp_pkg::PH_DIGITS: begin
        if (dig_ok) begin
          state_o.acc = acc_take;
          state_o.cnt = cnt_inc;
        end else begin
          emit_o        = 1'b1;
          state_o.phase = ilp_pkg::PH_IDLE;
        end
      end
      default: begin
        state_o = st;
      end
    endcase
  end

endmodule

@@ design/integer_literal_parser.sv @@
// top level of the streaming integer literal parser
//
// Usage: characters arrive one per input transaction on char_code_i, with
// starts_string_i high on the first character of each string. An optional
// '-' leads; "0" selects octal and "0x"/"0X" hex, otherwise decimal. The
// first character that is not a digit of the base (NUL included) ends the
// number and yields one output transaction: success_o, value_o (wrapping
// 32-bit, sign applied) and consumed_o (saturating at 255). Characters that
// do not start a string are dropped while no number is open.
// A terminator passes from the input register through the step logic into
// the result register, from which its result is taken. Throughput: one
// character per cycle while the receiver does not stall; the per-character
// update is a single shift-add pass between the input register and the
// parser state register.
// Reset clears the parser state and both valid flags; the block is then
// ready at once. When the receiver stalls, the result holds and the parser
// pauses: one more character can wait in the input register, after which
// in_ready_o stays low until the result is taken.
module integer_literal_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ilp_pkg::CHAR_BITS-1:0]       char_code_i,
  input  logic                                starts_string_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                success_o,
  output logic signed [ilp_pkg::OUT_BITS-1:0] value_o,
  output logic [ilp_pkg::CNT_BITS-1:0]        consumed_o
);

  logic                            in_valid_q, in_valid_d;
  logic [ilp_pkg::CHAR_BITS-1:0]   char_q;
  logic                            start_q;
  ilp_pkg::ilp_state_t             state_q, state_d;
  logic                            out_valid_q, out_valid_d;
  ilp_pkg::ilp_result_t            res_q, res_d;
  logic                            fire, emit, in_accept;

  // step the parser whenever a character is held and the result register can take a result
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_accept  = in_valid_i && in_ready_o;

  ilp_step u_step (
    .state_i  (state_q),
    .char_i   (char_q),
    .start_i  (start_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (res_d)
  );

  // valid flags
  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    out_valid_d = (fire && emit) || (out_valid_q && !out_ready_i);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.phase <= ilp_pkg::PH_IDLE;
      state_q.radix <= ilp_pkg::RAD_DEC;
      state_q.neg   <= 1'b0;
      state_q.acc   <= '0;
      state_q.cnt   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // input and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q  <= char_code_i;
      start_q <= starts_string_i;
    end
    if (fire && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign success_o   = res_q.success;
  assign value_o     = res_q.value;
  assign consumed_o  = res_q.consumed;

endmodule

@@ design/ilp_checker.sv @@
// port-level checks for the integer literal parser, bound to the top level
module ilp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [ilp_pkg::CHAR_BITS-1:0]       char_code_i,
  input logic                                starts_string_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                success_o,
  input logic signed [ilp_pkg::OUT_BITS-1:0] value_o,
  input logic [ilp_pkg::CNT_BITS-1:0]        consumed_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o)
      && $stable(success_o) && $stable(consumed_o))
    else $error("result changed while stalled");

  // a failed parse reports a zero value and count
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !success_o |-> (value_o == '0) && (consumed_o == '0))
    else $error("failed parse with nonzero fields");

  // success always comes with a consumed count
  a_succ_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && success_o |-> (consumed_o != '0))
    else $error("success with no characters consumed");

  // with the result register empty the input side never stalls
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (.*);
